FILE: rtl/lifegen_pkg.sv
// ----------------------------------------------------------------------------
// lifegen_pkg: shared types and constants of the life generation core
// Holds field widths, the item mode codes, the controller states, the
// rule constants of B3/S23 and the memory control group.
// ----------------------------------------------------------------------------
package lifegen_pkg;

    // Field widths of the stream items, the size register and the neighbour count.
    localparam int DATA_W = 64;
    localparam int ROW_W  = 6;
    localparam int MODE_W = 2;
    localparam int SIZE_W = 7;
    localparam int NBR_W  = 4;

    // Register reset value and lower clamp of the active board size.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;

    // Neighbour counts of rule B3/S23.
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    // What an input item asks for.
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE   = 2'd0,
        MODE_ADVANCE = 2'd1,
        MODE_READ    = 2'd2
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_RESP
    } t_state;

    // Control group from the controller to the board memory.
    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_en;
        logic rd_bank;
        logic clr_en;
        logic clr_bank;
    } t_mem_ctrl;

endpackage

FILE: rtl/lifegen_cell_lane.sv
// ----------------------------------------------------------------------------
// lifegen_cell_lane: next state of one cell
// Counts the eight neighbours of a cell and applies rule B3/S23.
// ----------------------------------------------------------------------------
module lifegen_cell_lane (
    input  logic [7:0] i_nbr,
    input  logic       i_self,
    output logic       o_next
);

    logic [lifegen_pkg::NBR_W-1:0] s_count;

    // Population count of the neighbourhood, then the birth and survival rule.
    always_comb begin
        s_count = '0;
        for (int k = 0; k < 8; k++) begin
            s_count = s_count + lifegen_pkg::NBR_W'(i_nbr[k]);
        end
        o_next = (s_count == lifegen_pkg::BIRTH_COUNT) ||
                 (i_self && (s_count == lifegen_pkg::SURVIVE_COUNT));
    end

endmodule

FILE: rtl/lifegen_row_update.sv
// ----------------------------------------------------------------------------
// lifegen_row_update: one row of a generation across all cell lanes
// Builds the wrapped neighbourhood of every column from three board rows,
// runs one lane per column and merges the lane results into the new row.
// ----------------------------------------------------------------------------
module lifegen_row_update #(
    parameter int MAX_SIZE = 64
) (
    input  logic [MAX_SIZE-1:0]             i_up,
    input  logic [MAX_SIZE-1:0]             i_mid,
    input  logic [MAX_SIZE-1:0]             i_dn,
    input  logic [lifegen_pkg::SIZE_W-1:0]  i_size,
    input  logic [MAX_SIZE-1:0]             i_mask,
    output logic [MAX_SIZE-1:0]             o_row
);

    localparam int AW = $clog2(MAX_SIZE);

    logic [AW-1:0]       s_last;
    logic [MAX_SIZE-1:0] s_hit;
    logic [MAX_SIZE-1:0] s_up_w, s_up_e, s_mid_w, s_mid_e, s_dn_w, s_dn_e;
    logic [MAX_SIZE-1:0] s_lane;

    function automatic logic [AW-1:0] s_hit_index(input logic [lifegen_pkg::SIZE_W-1:0] size);
        logic [lifegen_pkg::SIZE_W-1:0] last;
        last = size - lifegen_pkg::SIZE_W'(1);
        return last[AW-1:0];
    endfunction

    // The last active column; the left neighbour of column zero sits there.
    assign s_last = s_hit_index(i_size);

    // West and east neighbours of every column, wrapped on the active width.
    for (genvar c = 0; c < MAX_SIZE; c++) begin : g_col
        assign s_hit[c] = (i_size == lifegen_pkg::SIZE_W'(c + 1));

        if (c == 0) begin : g_west_wrap
            assign s_up_w[c]  = i_up[s_last];
            assign s_mid_w[c] = i_mid[s_last];
            assign s_dn_w[c]  = i_dn[s_last];
        end else begin : g_west
            assign s_up_w[c]  = i_up[c-1];
            assign s_mid_w[c] = i_mid[c-1];
            assign s_dn_w[c]  = i_dn[c-1];
        end

        if (c == MAX_SIZE - 1) begin : g_east_wrap
            assign s_up_e[c]  = i_up[0];
            assign s_mid_e[c] = i_mid[0];
            assign s_dn_e[c]  = i_dn[0];
        end else begin : g_east
            assign s_up_e[c]  = s_hit[c] ? i_up[0]  : i_up[c+1];
            assign s_mid_e[c] = s_hit[c] ? i_mid[0] : i_mid[c+1];
            assign s_dn_e[c]  = s_hit[c] ? i_dn[0]  : i_dn[c+1];
        end

        lifegen_cell_lane u_lane (
            .i_nbr  ({s_up_w[c], i_up[c], s_up_e[c], s_mid_w[c], s_mid_e[c],
                      s_dn_w[c], i_dn[c], s_dn_e[c]}),
            .i_self (i_mid[c]),
            .o_next (s_lane[c])
        );
    end

    // Merge the lanes; columns beyond the active width are cleared.
    assign o_row = s_lane & i_mask;

endmodule

FILE: rtl/lifegen_board_mem.sv
// ----------------------------------------------------------------------------
// lifegen_board_mem: two banks of board rows with per-row valid bits
// One bank holds the current board while a generation fills the other.
// A row whose valid bit is clear reads as all cells dead.
// ----------------------------------------------------------------------------
module lifegen_board_mem #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lifegen_pkg::t_mem_ctrl        i_ctrl,
    input  logic [$clog2(MAX_SIZE)-1:0]   i_wr_addr,
    input  logic [MAX_SIZE-1:0]           i_wr_data,
    input  logic [$clog2(MAX_SIZE)-1:0]   i_rd_addr,
    output logic [MAX_SIZE-1:0]           o_rd_data
);

    localparam int AW    = $clog2(MAX_SIZE);
    localparam int DEPTH = 2 ** (AW + 1);

    logic [MAX_SIZE-1:0]         r_mem [DEPTH];
    logic [1:0][MAX_SIZE-1:0]    r_valid;
    logic [MAX_SIZE-1:0]         r_rd_data;
    logic                        r_rd_valid;

    // Row storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[{i_ctrl.wr_bank, i_wr_addr}] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[{i_ctrl.rd_bank, i_rd_addr}];
        end
    end

    // Valid bits: reset and bank clears empty the board, writes fill rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr_en) begin
                r_valid[i_ctrl.clr_bank] <= '0;
            end
            if (i_ctrl.wr_en) begin
                r_valid[i_ctrl.wr_bank][i_wr_addr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_valid <= r_valid[i_ctrl.rd_bank][i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/life_automaton_generation_core.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_core: toroidal B3/S23 life board
// Holds a square board of one-bit cells whose edges wrap on both axes.
// ----------------------------------------------------------------------------
// Input items arrive on the slave stream: tuser carries the mode (write row,
// advance one generation, read row), tdata the row index and the row bits.
// Every input item yields exactly one item on the master stream: the active
// cells of the row for a read, zero for every other mode. The board size is
// set through i_cfg_we / i_cfg_wdata; the user must write it only while the
// core is idle, which the core does not enforce. Values below three act as
// three and values above MAX_SIZE act as MAX_SIZE. A write result loads a
// free output register on acceptance; a read passes the memory read register
// first. A generation sweeps the board one row per cycle through the single
// read port of the memory. The core takes one item at a time; it accepts the
// next item while a result still waits in the output register, but holds
// the following result until the receiver takes the waiting one.
// Reset empties the board at once through per-row valid bits, selects the
// first memory bank and sets the size to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module life_automaton_generation_core #(
    parameter int MAX_SIZE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: board size.
    input  logic                                i_cfg_we,
    input  logic [lifegen_pkg::SIZE_W-1:0]      i_cfg_wdata,
    // Slave stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [71:0]                         i_s_tdata,  // row_index[5:0], row_bits[69:6]
    input  logic [lifegen_pkg::MODE_W-1:0]      i_s_tuser,  // mode[1:0]
    // Master stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lifegen_pkg::DATA_W-1:0]      o_m_tdata   // row_data[63:0]
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int SW = lifegen_pkg::SIZE_W;

    // Registers.
    lifegen_pkg::t_state            r_state, n_state;
    logic                           r_cur, n_cur;
    logic                           r_resp_read, n_resp_read;
    logic                           r_out_valid, n_out_valid;
    logic [lifegen_pkg::DATA_W-1:0] r_out_data, n_out_data;
    logic [SW-1:0]                  r_board_size;
    logic [SW-1:0]                  r_rd_cnt, n_rd_cnt;
    logic                           r_rd_pend, n_rd_pend;
    logic [1:0]                     r_fill, n_fill;
    logic                           r_win_new, n_win_new;
    logic [AW-1:0]                  r_wr_row, n_wr_row;
    logic [MAX_SIZE-1:0]            r_up, r_mid, r_dn;

    // Combinational signals.
    logic [SW-1:0]                  s_size;
    logic [MAX_SIZE-1:0]            s_mask;
    logic                           s_accept;
    logic                           s_out_free;
    logic                           s_load_out;
    logic                           s_gen_done;
    lifegen_pkg::t_mode             s_mode;
    logic [lifegen_pkg::ROW_W-1:0]  s_row_idx;
    logic                           s_row_ok;
    logic [SW-1:0]                  s_last;
    logic [SW-1:0]                  s_rd_row;
    lifegen_pkg::t_mem_ctrl         s_mem;
    logic [AW-1:0]                  s_wr_addr, s_rd_addr;
    logic [MAX_SIZE-1:0]            s_wr_data;
    logic [MAX_SIZE-1:0]            s_rd_data;
    logic [MAX_SIZE-1:0]            s_new_row;

    // Active size, clamped to the supported range, and its column mask.
    always_comb begin
        if (r_board_size < lifegen_pkg::SIZE_MIN) begin
            s_size = lifegen_pkg::SIZE_MIN;
        end else if (r_board_size > SW'(MAX_SIZE)) begin
            s_size = SW'(MAX_SIZE);
        end else begin
            s_size = r_board_size;
        end
        for (int c = 0; c < MAX_SIZE; c++) begin
            s_mask[c] = (SW'(c) < s_size);
        end
    end

    assign s_last     = s_size - SW'(1);
    assign s_mode     = lifegen_pkg::t_mode'(i_s_tuser);
    assign s_row_idx  = i_s_tdata[5:0];
    assign s_row_ok   = ({1'b0, s_row_idx} < s_size);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_out_free = !r_out_valid || i_m_tready;
    assign s_gen_done = (r_state == lifegen_pkg::ST_GEN) && r_win_new &&
                        (r_wr_row == s_last[AW-1:0]);

    // Read row sequence of a generation: last row, rows 0 to n-1, row 0 again.
    always_comb begin
        if (r_rd_cnt == '0) begin
            s_rd_row = s_last;
        end else if (r_rd_cnt == s_size + SW'(1)) begin
            s_rd_row = '0;
        end else begin
            s_rd_row = r_rd_cnt - SW'(1);
        end
    end

    // Controller: next state, memory control and output register load.
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_resp_read = r_resp_read;
        n_rd_cnt    = r_rd_cnt;
        n_rd_pend   = 1'b0;
        n_fill      = r_fill;
        n_win_new   = 1'b0;
        n_wr_row    = r_wr_row;
        s_mem       = '0;
        s_wr_addr   = s_row_idx[AW-1:0];
        s_wr_data   = i_s_tdata[MAX_SIZE+5:6] & s_mask;
        s_rd_addr   = s_row_idx[AW-1:0];
        s_load_out  = 1'b0;
        n_out_data  = '0;
        o_s_tready  = (r_state == lifegen_pkg::ST_IDLE);

        case (r_state)
            lifegen_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (s_mode)
                        lifegen_pkg::MODE_WRITE: begin
                            s_mem.wr_en   = s_row_ok;
                            s_mem.wr_bank = r_cur;
                            n_resp_read   = 1'b0;
                            if (s_out_free) begin
                                s_load_out = 1'b1;
                            end else begin
                                n_state = lifegen_pkg::ST_RESP;
                            end
                        end
                        lifegen_pkg::MODE_READ: begin
                            if (s_row_ok) begin
                                s_mem.rd_en   = 1'b1;
                                s_mem.rd_bank = r_cur;
                                n_resp_read   = 1'b1;
                                n_state       = lifegen_pkg::ST_RESP;
                            end else if (s_out_free) begin
                                s_load_out = 1'b1;
                            end else begin
                                n_resp_read = 1'b0;
                                n_state     = lifegen_pkg::ST_RESP;
                            end
                        end
                        lifegen_pkg::MODE_ADVANCE: begin
                            s_mem.clr_en   = 1'b1;
                            s_mem.clr_bank = !r_cur;
                            n_rd_cnt       = '0;
                            n_fill         = '0;
                            n_wr_row       = '0;
                            n_state        = lifegen_pkg::ST_GEN;
                        end
                        default: begin
                            n_resp_read = 1'b0;
                            if (s_out_free) begin
                                s_load_out = 1'b1;
                            end else begin
                                n_state = lifegen_pkg::ST_RESP;
                            end
                        end
                    endcase
                end
            end

            lifegen_pkg::ST_GEN: begin
                // Issue the next row read from the current bank.
                if (r_rd_cnt != s_size + SW'(2)) begin
                    s_mem.rd_en   = 1'b1;
                    s_mem.rd_bank = r_cur;
                    s_rd_addr     = s_rd_row[AW-1:0];
                    n_rd_cnt      = r_rd_cnt + SW'(1);
                    n_rd_pend     = 1'b1;
                end
                // A row arrives: the window moves down by one row.
                if (r_rd_pend) begin
                    if (r_fill != 2'd3) begin
                        n_fill = r_fill + 2'd1;
                    end
                    n_win_new = (r_fill >= 2'd2);
                end
                // A full window gives one new row to the other bank.
                if (r_win_new) begin
                    s_mem.wr_en   = 1'b1;
                    s_mem.wr_bank = !r_cur;
                    s_wr_addr     = r_wr_row;
                    s_wr_data     = s_new_row;
                    n_wr_row      = r_wr_row + AW'(1);
                end
                if (s_gen_done) begin
                    n_cur       = !r_cur;
                    n_resp_read = 1'b0;
                    if (s_out_free) begin
                        s_load_out = 1'b1;
                        n_state    = lifegen_pkg::ST_IDLE;
                    end else begin
                        n_state = lifegen_pkg::ST_RESP;
                    end
                end
            end

            lifegen_pkg::ST_RESP: begin
                if (s_out_free) begin
                    s_load_out = 1'b1;
                    n_out_data = r_resp_read ?
                                 lifegen_pkg::DATA_W'(s_rd_data & s_mask) : '0;
                    n_state    = lifegen_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lifegen_pkg::ST_IDLE;
            end
        endcase

        if (s_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lifegen_pkg::ST_IDLE;
            r_cur        <= 1'b0;
            r_resp_read  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_board_size <= lifegen_pkg::SIZE_RESET;
            r_rd_cnt     <= '0;
            r_rd_pend    <= 1'b0;
            r_fill       <= '0;
            r_win_new    <= 1'b0;
            r_wr_row     <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_resp_read <= n_resp_read;
            r_out_valid <= n_out_valid;
            r_rd_cnt    <= n_rd_cnt;
            r_rd_pend   <= n_rd_pend;
            r_fill      <= n_fill;
            r_win_new   <= n_win_new;
            r_wr_row    <= n_wr_row;
            if (i_cfg_we) begin
                r_board_size <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: the result item and the three-row window.
    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out_data <= n_out_data;
        end
        if (r_state == lifegen_pkg::ST_GEN && r_rd_pend) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= s_rd_data;
        end
    end

    // Board rows in two banks.
    lifegen_board_mem #(
        .MAX_SIZE (MAX_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s_mem),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    // One new row from the window, all columns in parallel.
    lifegen_row_update #(
        .MAX_SIZE (MAX_SIZE)
    ) u_row (
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_dn   (r_dn),
        .i_size (s_size),
        .i_mask (s_mask),
        .o_row  (s_new_row)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A finished generation hands the board over to the other bank.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_gen_done |=> (r_cur != $past(r_cur)))
        else $error("bank select did not flip after a generation");

    // A generation never overwrites the bank that it is reading.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lifegen_pkg::ST_GEN && s_mem.wr_en) |-> (s_mem.wr_bank != r_cur))
        else $error("generation wrote into the current board");

    // New rows are only written once the window holds three rows.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lifegen_pkg::ST_GEN && r_win_new) |-> (r_fill == 2'd3))
        else $error("row written from an incomplete window");

    // A result is never loaded over one that the receiver has not taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load_out |-> (!r_out_valid || i_m_tready))
        else $error("result item overwritten before delivery");

endmodule
